/* rtl/lms_adaptive_fir_core_macros.svh */
// assertion macros shared by the lms adaptive fir checker
`ifndef LMS_ADAPTIVE_FIR_CORE_MACROS_SVH
`define LMS_ADAPTIVE_FIR_CORE_MACROS_SVH

// next-cycle property, ignored while reset is high
`define LAFIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lafir check failed");

// property checked in the cycle that follows a reset cycle
`define LAFIR_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("lafir reset check failed");

`endif

/* rtl/lafir_pkg.sv */
// constants, types and helper functions of the lms adaptive fir
package lafir_pkg;

  localparam int TAPS       = 128;
  localparam int ADDR_W     = $clog2(TAPS);
  localparam int CNT_W      = $clog2(TAPS + 1);

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 32;
  localparam int STEP_W     = 24;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(16777);

  localparam int EX_W       = 2 * SAMPLE_W;
  localparam int UPD_W      = EX_W + STEP_W + 1;
  localparam int UPD_SHIFT  = 25;
  localparam int PROD_W     = COEF_W + SAMPLE_W;
  localparam int ACC_W      = PROD_W + $clog2(TAPS);
  localparam int EST_SHIFT  = 28;
  localparam int EST_W      = ACC_W - EST_SHIFT;
  localparam int ERR_W      = EST_W + 1;

  typedef struct packed {
    logic              vld;
    logic              prime;
    logic              last;
    logic [ADDR_W-1:0] k;
  } tap_cmd_t;

  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        addr;
    logic signed [COEF_W-1:0] data;
  } coef_wr_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_q15(input logic signed [ERR_W-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[ERR_W-1:SAMPLE_W-1];
    hi_zeros = ~|v[ERR_W-1:SAMPLE_W-1];
    if (hi_ones || hi_zeros) begin
      return v[SAMPLE_W-1:0];
    end
    return v[ERR_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
  endfunction

  function automatic logic signed [COEF_W-1:0] sat_coef(input logic [COEF_W:0] v);
    if (v[COEF_W] == v[COEF_W-1]) begin
      return v[COEF_W-1:0];
    end
    return v[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
  endfunction

endpackage

/* rtl/lafir_ifs.sv */
// handshake channel interfaces of the lms adaptive fir
interface lafir_sample_if import lafir_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] reference_sample;
  logic signed [SAMPLE_W-1:0] desired_sample;

  modport source (output valid, output reference_sample, output desired_sample, input ready);
  modport sink (input valid, input reference_sample, input desired_sample, output ready);
endinterface

interface lafir_result_if import lafir_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filter_output;
  logic signed [SAMPLE_W-1:0] error_sample;

  modport source (output valid, output filter_output, output error_sample, input ready);
  modport sink (input valid, input filter_output, input error_sample, output ready);
endinterface

interface lafir_cfg_if import lafir_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] step_size;

  modport source (output valid, output step_size, input ready);
  modport sink (input valid, input step_size, output ready);
endinterface

/* rtl/lafir_ram.sv */
// generic simple dual-port ram with registered read
module lafir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lafir_tap_pipe.sv */
// per-tap pipeline: pending coefficient update, write back and multiply-accumulate
module lafir_tap_pipe import lafir_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  tap_cmd_t                   cmd,
  input  logic signed [COEF_W-1:0]   coef_q,
  input  logic signed [SAMPLE_W-1:0] dl_q,
  input  logic signed [SAMPLE_W-1:0] new_sample,
  input  logic signed [SAMPLE_W-1:0] err_prev,
  input  logic [STEP_W-1:0]          mu_prev,
  output coef_wr_t                   coef_wr,
  output logic signed [ACC_W-1:0]    acc,
  output logic                       done
);

  localparam logic signed [UPD_W-1:0] UPD_ROUND = UPD_W'(1) <<< (UPD_SHIFT - 1);

  logic signed [SAMPLE_W-1:0] x_k;
  logic signed [SAMPLE_W-1:0] xprev;
  logic signed [EX_W-1:0]     ex_next;
  logic signed [STEP_W:0]     mu_s;
  logic signed [UPD_W-1:0]    p_next;
  logic signed [UPD_W-1:0]    p_rnd;
  logic signed [COEF_W-1:0]   delta;
  logic [COEF_W:0]            csum;
  logic signed [COEF_W-1:0]   coef_new;
  logic signed [PROD_W-1:0]   prod_next;

  logic                       a_vld, a_last;
  logic [ADDR_W-1:0]          a_k;
  logic signed [COEF_W-1:0]   a_coef;
  logic signed [SAMPLE_W-1:0] a_x;
  logic signed [EX_W-1:0]     a_ex;

  logic                       b_vld, b_last;
  logic [ADDR_W-1:0]          b_k;
  logic signed [COEF_W-1:0]   b_coef;
  logic signed [SAMPLE_W-1:0] b_x;
  logic signed [UPD_W-1:0]    b_p;

  logic                       c_vld, c_last;
  logic signed [COEF_W-1:0]   c_coef;
  logic signed [SAMPLE_W-1:0] c_x;

  logic                       d_vld, d_last;
  logic signed [PROD_W-1:0]   d_prod;

  // tap zero takes the incoming sample, it is not in the delay ram yet
  assign x_k       = cmd.last ? new_sample : dl_q;
  assign ex_next   = err_prev * xprev;
  assign mu_s      = $signed({1'b0, mu_prev});
  assign p_next    = a_ex * mu_s;
  assign p_rnd     = b_p + UPD_ROUND;
  assign delta     = p_rnd[UPD_W-1:UPD_SHIFT];
  assign csum      = {b_coef[COEF_W-1], b_coef} + {delta[COEF_W-1], delta};
  assign coef_new  = sat_coef(csum);
  assign prod_next = c_coef * c_x;

  assign coef_wr.we   = b_vld;
  assign coef_wr.addr = b_k;
  assign coef_wr.data = coef_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      a_vld <= cmd.vld && !cmd.prime;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      done  <= d_vld && d_last;
    end

    // first read of a pass is the oldest sample, used only by the update
    if (cmd.vld && cmd.prime) begin
      xprev <= dl_q;
      acc   <= '0;
    end else begin
      if (cmd.vld) begin
        xprev <= x_k;
      end
      if (d_vld) begin
        acc <= acc + ACC_W'(d_prod);
      end
    end

    a_last <= cmd.last;
    a_k    <= cmd.k;
    a_coef <= coef_q;
    a_x    <= x_k;
    a_ex   <= ex_next;

    b_last <= a_last;
    b_k    <= a_k;
    b_coef <= a_coef;
    b_x    <= a_x;
    b_p    <= p_next;

    c_last <= b_last;
    c_coef <= coef_new;
    c_x    <= b_x;

    d_last <= c_last;
    d_prod <= prod_next;
  end

endmodule

/* rtl/lms_adaptive_fir_core.sv */
// lms adaptive fir top level: sequencer, delay and coefficient rams, result register
// After reset the block clears both rams, one entry a cycle, before it takes the
// first word. It takes no new word while a pass or its drain is under way. One pass
// of TAPS + 1 reads walks the taps through a single shared update and
// multiply-accumulate pipeline, reading one coefficient and one delayed sample per
// cycle. The pipeline then drains, and the result is written to the output register.
// The coefficient update that belongs to a word is applied during the pass of the
// next word, on its way into the dot product, so its results are the same. A
// finished result waits in an output register while the next word is taken. If that
// register still holds an untaken result when the next pass ends, the block waits
// until the result is taken. Step size writes take effect from the next word.
module lms_adaptive_fir_core import lafir_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  lafir_sample_if.sink   samples,
  lafir_result_if.source results,
  lafir_cfg_if.sink      cfg
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t                     state;
  logic [ADDR_W-1:0]          clr_addr;
  logic [ADDR_W-1:0]          ptr;
  logic [ADDR_W-1:0]          rd_addr;
  logic [CNT_W-1:0]           iss_cnt;
  logic [ADDR_W-1:0]          tap_k;
  logic signed [SAMPLE_W-1:0] ref_q;
  logic signed [SAMPLE_W-1:0] des_q;
  logic [STEP_W-1:0]          step_size;
  logic signed [SAMPLE_W-1:0] err_prev;
  logic [STEP_W-1:0]          mu_prev;
  logic                       res_valid;
  logic signed [SAMPLE_W-1:0] res_filter;
  logic signed [SAMPLE_W-1:0] res_error;
  tap_cmd_t                   cmd;
  tap_cmd_t                   cmd_q;

  coef_wr_t                   coef_wr;
  logic signed [ACC_W-1:0]    acc;
  logic                       done;

  logic                       dl_we;
  logic [ADDR_W-1:0]          dl_waddr;
  logic [SAMPLE_W-1:0]        dl_wdata;
  logic [SAMPLE_W-1:0]        dl_rdata;
  logic                       cf_we;
  logic [ADDR_W-1:0]          cf_waddr;
  logic [COEF_W-1:0]          cf_wdata;
  logic [COEF_W-1:0]          cf_rdata;

  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [EST_W-1:0]    est;
  logic signed [ERR_W-1:0]    err_wide;
  logic signed [SAMPLE_W-1:0] err_sat;
  logic                       out_free;

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a);
    return (a == ADDR_W'(TAPS - 1)) ? '0 : a + 1'b1;
  endfunction

  assign samples.ready         = (state == S_IDLE);
  assign cfg.ready             = 1'b1;
  assign results.valid         = res_valid;
  assign results.filter_output = res_filter;
  assign results.error_sample  = res_error;

  assign cmd.vld   = (state == S_RUN);
  assign cmd.prime = (iss_cnt == '0);
  assign cmd.last  = (iss_cnt == CNT_W'(TAPS));
  assign cmd.k     = tap_k;

  // new sample goes into the slot of the oldest one once that has been read
  assign dl_we    = (state == S_CLEAR) || (cmd.vld && cmd.last);
  assign dl_waddr = (state == S_CLEAR) ? clr_addr : ptr;
  assign dl_wdata = (state == S_CLEAR) ? '0 : ref_q;

  assign cf_we    = (state == S_CLEAR) || coef_wr.we;
  assign cf_waddr = (state == S_CLEAR) ? clr_addr : coef_wr.addr;
  assign cf_wdata = (state == S_CLEAR) ? '0 : coef_wr.data;

  assign acc_rnd  = acc + (ACC_W'(1) <<< (EST_SHIFT - 1));
  assign est      = acc_rnd[ACC_W-1:EST_SHIFT];
  assign err_wide = ERR_W'(des_q) - ERR_W'(est);
  assign err_sat  = sat_q15(err_wide);
  assign out_free = !res_valid || results.ready;

  lafir_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TAPS)
  ) u_delay_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (rd_addr),
    .rdata (dl_rdata)
  );

  lafir_ram #(
    .WIDTH (COEF_W),
    .DEPTH (TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (cf_we),
    .waddr (cf_waddr),
    .wdata (cf_wdata),
    .raddr (tap_k),
    .rdata (cf_rdata)
  );

  lafir_tap_pipe u_tap_pipe (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_q),
    .coef_q     ($signed(cf_rdata)),
    .dl_q       ($signed(dl_rdata)),
    .new_sample (ref_q),
    .err_prev   (err_prev),
    .mu_prev    (mu_prev),
    .coef_wr    (coef_wr),
    .acc        (acc),
    .done       (done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      ptr       <= '0;
      step_size <= STEP_RESET;
      err_prev  <= '0;
      mu_prev   <= '0;
      res_valid <= 1'b0;
      cmd_q     <= '0;
    end else begin
      cmd_q <= cmd;
      if (cfg.valid && cfg.ready) begin
        step_size <= cfg.step_size;
      end
      if (results.ready && state != S_FINISH) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(TAPS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (samples.valid) begin
            ref_q   <= samples.reference_sample;
            des_q   <= samples.desired_sample;
            rd_addr <= ptr;
            iss_cnt <= '0;
            tap_k   <= ADDR_W'(TAPS - 1);
            state   <= S_RUN;
          end
        end
        S_RUN: begin
          iss_cnt <= iss_cnt + 1'b1;
          rd_addr <= wrap_inc(rd_addr);
          if (!cmd.prime) begin
            tap_k <= tap_k - 1'b1;
          end
          if (cmd.last) begin
            ptr   <= wrap_inc(ptr);
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            res_valid  <= 1'b1;
            res_filter <= sat_q15(ERR_W'(est));
            res_error  <= err_sat;
            err_prev   <= err_sat;
            mu_prev    <= step_size;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

/* rtl/lafir_checker.sv */
// port-level checker of the lms adaptive fir and its bind
`include "lms_adaptive_fir_core_macros.svh"

module lafir_checker import lafir_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_filter,
  input logic [SAMPLE_W-1:0] out_error
);

  // clearing pass follows reset, nothing is taken or shown
  `LAFIR_ASSERT_RESET(a_clear_after_reset, !in_ready && !out_valid)

  // one word in flight: a taken word keeps the input closed for a while
  `LAFIR_ASSERT_NEXT(a_one_word_at_a_time, in_valid && in_ready, !in_ready ##1 !in_ready)

  `LAFIR_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(out_filter) && $stable(out_error))

endmodule

bind lms_adaptive_fir_core lafir_checker u_lafir_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_filter (results.filter_output),
  .out_error  (results.error_sample)
);

/* test/tb_lms_adaptive_fir_core.sv */
`timescale 1ns / 100ps
// self-checking testbench of the lms adaptive fir core with an in-bench fixed-point predictor
module tb_lms_adaptive_fir_core;
  import lafir_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 800;
  localparam int RANDOM_WORDS = 750;
  localparam int WORD_CYCLES = 136;
  localparam int MAX_PRINTED = 100;

  typedef enum logic [1:0] {OP_SAMPLE, OP_STEP_WRITE, OP_DRAIN} stim_kind_t;

  typedef struct {
    stim_kind_t                 kind;
    logic signed [SAMPLE_W-1:0] ref_s;
    logic signed [SAMPLE_W-1:0] des_s;
    logic [STEP_W-1:0]          step;
  } stim_op_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] filter_output;
    logic signed [SAMPLE_W-1:0] error_sample;
  } estimate_t;

  logic clk;
  logic rst;

  lafir_sample_if samples_if ();
  lafir_result_if results_if ();
  lafir_cfg_if    cfg_if ();

  lms_adaptive_fir_core u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  stim_op_t  stim_q[$];
  estimate_t estimate_q[$];

  // predictor state
  logic signed [SAMPLE_W-1:0] history [TAPS];
  logic signed [COEF_W-1:0]   weights [TAPS];
  logic [STEP_W-1:0]          mu_reg;

  bit sample_fire;
  bit cfg_fire;
  bit result_fire;
  int mismatch_count;
  int idle_cycles;

  int gap_left;
  bit tx_idle_on;
  int rx_wait;
  int hold_left;
  int results_seen;
  bit rx_idle_on;

  always #5 clk = ~clk;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // shift in the reference word, estimate with the old weights, then adapt
  task automatic adapt_and_estimate(input logic signed [SAMPLE_W-1:0] ref_s,
                                    input logic signed [SAMPLE_W-1:0] des_s);
    longint    acc;
    longint    est;
    longint    err;
    longint    mu;
    longint    prod;
    longint    delta;
    estimate_t res;
    int        k;
    for (k = TAPS - 1; k > 0; k--) begin
      history[k] = history[k - 1];
    end
    history[0] = ref_s;
    acc = 0;
    for (k = 0; k < TAPS; k++) begin
      acc += longint'(weights[k]) * longint'(history[k]);
    end
    est = (acc + (longint'(1) <<< 27)) >>> 28;
    err = clamp(longint'(des_s) - est, -32768, 32767);
    mu = longint'(mu_reg);
    for (k = 0; k < TAPS; k++) begin
      prod = mu * err * longint'(history[k]);
      delta = (prod + (longint'(1) <<< 24)) >>> 25;
      weights[k] = COEF_W'(clamp(longint'(weights[k]) + delta,
                                 -64'sd2147483648, 64'sd2147483647));
    end
    res.filter_output = SAMPLE_W'(clamp(est, -32768, 32767));
    res.error_sample = SAMPLE_W'(err);
    estimate_q.push_back(res);
  endtask

  function automatic void push_sample(input int r, input int d);
    stim_op_t op;
    op.kind = OP_SAMPLE;
    op.ref_s = SAMPLE_W'(r);
    op.des_s = SAMPLE_W'(d);
    op.step = '0;
    stim_q.push_back(op);
  endfunction

  function automatic void push_step(input logic [STEP_W-1:0] v);
    stim_op_t op;
    op.kind = OP_STEP_WRITE;
    op.ref_s = '0;
    op.des_s = '0;
    op.step = v;
    stim_q.push_back(op);
  endfunction

  function automatic void push_drain();
    stim_op_t op;
    op.kind = OP_DRAIN;
    op.ref_s = '0;
    op.des_s = '0;
    op.step = '0;
    stim_q.push_back(op);
  endfunction

  function automatic int rand_word();
    return int'($signed(16'($urandom)));
  endfunction

  // monitor: prediction on accepted words, checking of accepted results
  always @(posedge clk) begin : monitor
    estimate_t want;
    sample_fire <= !rst && samples_if.valid && samples_if.ready;
    cfg_fire <= !rst && cfg_if.valid && cfg_if.ready;
    result_fire <= !rst && results_if.valid && results_if.ready;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        mu_reg = cfg_if.step_size;
      end
      if (samples_if.valid && samples_if.ready) begin
        adapt_and_estimate(samples_if.reference_sample, samples_if.desired_sample);
      end
      if (results_if.valid && results_if.ready) begin
        if (estimate_q.size() == 0) begin
          report_mismatch("result word with nothing pending", results_if.filter_output, 0);
        end else begin
          want = estimate_q.pop_front();
          if (results_if.filter_output !== want.filter_output) begin
            report_mismatch("filter_output", results_if.filter_output, want.filter_output);
          end
          if (results_if.error_sample !== want.error_sample) begin
            report_mismatch("error_sample", results_if.error_sample, want.error_sample);
          end
        end
      end
    end
  end

  // watchdog on cycles with no word accepted anywhere
  always @(posedge clk) begin
    if (rst || (samples_if.valid && samples_if.ready) || (cfg_if.valid && cfg_if.ready)
        || (results_if.valid && results_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // driver
  always @(negedge clk) begin : driver
    logic v_next;
    logic c_next;
    v_next = samples_if.valid;
    c_next = cfg_if.valid;
    if (!rst) begin
      if (sample_fire) begin
        v_next = 1'b0;
      end
      if (cfg_fire) begin
        c_next = 1'b0;
      end
      if (!v_next && !c_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0) begin
          case (stim_q[0].kind)
            OP_SAMPLE: begin
              samples_if.reference_sample <= stim_q[0].ref_s;
              samples_if.desired_sample <= stim_q[0].des_s;
              v_next = 1'b1;
              void'(stim_q.pop_front());
              if ($urandom_range(0, 30) == 0) begin
                tx_idle_on = !tx_idle_on;
              end
              gap_left = tx_idle_on ? $urandom_range(0, 10) : 0;
            end
            OP_STEP_WRITE: begin
              if (estimate_q.size() == 0) begin
                cfg_if.step_size <= stim_q[0].step;
                c_next = 1'b1;
                void'(stim_q.pop_front());
              end
            end
            default: begin
              if (estimate_q.size() == 0) begin
                void'(stim_q.pop_front());
              end
            end
          endcase
        end
      end
    end
    samples_if.valid <= v_next;
    cfg_if.valid <= c_next;
  end

  // receiver with random stalls and two long hold-offs
  always @(negedge clk) begin : receiver
    logic r_next;
    r_next = results_if.ready;
    if (!rst) begin
      if (result_fire) begin
        results_seen++;
        if ($urandom_range(0, 30) == 0) begin
          rx_idle_on = !rx_idle_on;
        end
        rx_wait = rx_idle_on ? $urandom_range(0, 10) : 0;
        if (results_seen == 60 || results_seen == 400) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        r_next = 1'b0;
      end else if (rx_wait > 0) begin
        if (results_if.valid) begin
          rx_wait--;
        end
        r_next = 1'b0;
      end else begin
        r_next = 1'b1;
      end
    end
    results_if.ready <= r_next;
  end

  initial begin
    int random_words;
    int len;
    int pattern;
    int g0;
    int g1;
    int shift;
    int r;
    int d;
    int prev;
    int extremes[5];
    int i;
    int k;
    clk = 1'b0;
    rst = 1'b1;
    samples_if.valid = 1'b0;
    samples_if.reference_sample = '0;
    samples_if.desired_sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.step_size = '0;
    results_if.ready = 1'b0;
    mismatch_count = 0;
    idle_cycles = 0;
    gap_left = 0;
    tx_idle_on = 1'b1;
    rx_wait = 0;
    hold_left = 0;
    results_seen = 0;
    rx_idle_on = 1'b1;
    for (k = 0; k < TAPS; k++) begin
      history[k] = '0;
      weights[k] = '0;
    end
    mu_reg = STEP_RESET;
    extremes = '{-32768, 32767, 0, -1, 1};

    // field extremes at the reset step size
    push_sample(0, 0);
    push_sample(32767, 0);
    push_sample(-32768, 0);
    push_sample(0, 32767);
    push_sample(0, -32768);
    push_sample(32767, 32767);
    push_sample(-32768, -32768);
    push_sample(32767, -32768);
    push_sample(-32768, 32767);
    push_sample(1, -1);
    push_sample(-1, 1);
    push_sample(16'h5555, 16'haaaa);
    push_sample(16'haaaa, 16'h5555);
    // full step: coefficient, output and error saturation
    push_drain();
    push_step('1);
    for (i = 0; i < 4; i++) begin
      push_sample(32767, 32767);
    end
    for (i = 0; i < 4; i++) begin
      push_sample(32767, -32768);
    end
    push_sample(-32768, 32767);
    push_sample(-32768, 32767);
    // zero step freezes the weights
    push_drain();
    push_step('0);
    push_sample(12345, -23456);
    push_sample(-32768, 32767);
    push_sample(32767, -32768);

    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      push_drain();
      case ($urandom_range(0, 6))
        0: push_step('0);
        1: push_step('1);
        2: push_step(STEP_W'(1));
        3: push_step(STEP_RESET);
        4: push_step(STEP_W'($urandom));
        default: push_step(STEP_W'($urandom_range(1, 1 << 18)));
      endcase
      len = $urandom_range(30, 80);
      pattern = $urandom_range(0, 5);
      g0 = $urandom_range(0, 32) - 16;
      g1 = $urandom_range(0, 32) - 16;
      shift = $urandom_range(0, 8);
      prev = 0;
      for (i = 0; i < len; i++) begin
        case (pattern)
          0: begin
            r = rand_word();
            d = rand_word();
          end
          1, 2: begin
            // unknown two-tap plant with a little noise
            r = rand_word() >>> shift;
            d = int'(clamp(longint'(((r * g0 + prev * g1) >>> 3)
                                   + int'($urandom_range(0, 15)) - 8), -32768, 32767));
          end
          3: begin
            r = $urandom_range(0, 511) - 256;
            d = $urandom_range(0, 511) - 256;
          end
          4: begin
            r = extremes[$urandom_range(0, 4)];
            d = extremes[$urandom_range(0, 4)];
          end
          default: begin
            r = rand_word();
            d = ($urandom_range(0, 9) == 0) ? rand_word() : r;
          end
        endcase
        prev = r;
        push_sample(r, d);
        if (i == len / 2 && $urandom_range(0, 3) == 0) begin
          push_drain();
        end
      end
      random_words += len;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || samples_if.valid || cfg_if.valid || estimate_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (2 * WORD_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
